>>> design/tmtw_pkg.sv
package tmtw_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CNT_W = $clog2(CELL_COUNT + 1);

    localparam int ROW_W = 5;
    localparam int COL_W = 7;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;

    localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BS = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] RESET_COLOR = 8'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        CMD_READ,
        CMD_READ_NONE,
        CMD_IGNORE,
        CMD_NEWLINE,
        CMD_BACKSPACE,
        CMD_PRINT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } cmd_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
    } result_t;

endpackage

>>> design/tmtw_front.sv
module tmtw_front (
    input  logic                          push,
    input  logic                          opcode,
    input  logic [tmtw_pkg::CHAR_W-1:0]   char_code,
    input  logic [tmtw_pkg::ROW_W-1:0]    read_row,
    input  logic [tmtw_pkg::COL_W-1:0]    read_col,
    input  logic                          q_full,
    input  logic                          clearing,
    output logic                          full,
    output logic                          q_push,
    output tmtw_pkg::cmd_t                cmd
);
    import tmtw_pkg::*;

    logic in_range;

    assign in_range = (32'(read_row) < SCREEN_ROWS) && (32'(read_col) < SCREEN_COLUMNS);
    assign full = q_full | clearing;
    assign q_push = push & ~full;

    always_comb
    begin
        cmd.char_code = char_code;
        cmd.read_row = read_row;
        cmd.read_col = read_col;
        if (opcode == OP_READ)
        begin
            cmd.kind = in_range ? CMD_READ : CMD_READ_NONE;
        end
        else if (char_code == CH_CR)
        begin
            cmd.kind = CMD_IGNORE;
        end
        else if (char_code == CH_LF)
        begin
            cmd.kind = CMD_NEWLINE;
        end
        else if (char_code == CH_BS)
        begin
            cmd.kind = CMD_BACKSPACE;
        end
        else
        begin
            cmd.kind = CMD_PRINT;
        end
    end

endmodule

>>> design/tmtw_cmd_queue.sv
module tmtw_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tmtw_pkg::cmd_t cmd_in,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output tmtw_pkg::cmd_t cmd_out
);
    import tmtw_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign cmd_out = entry_reg[rd_ptr_reg];
    assign do_push = push & ~full;
    assign do_pop = pop & valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

>>> design/tmtw_back.sv
module tmtw_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  tmtw_pkg::cmd_t                cmd,
    output logic                          cmd_pop,
    input  logic                          color_we,
    input  logic [tmtw_pkg::CHAR_W-1:0]   color_data,
    output logic                          clearing,
    output logic                          res_empty,
    input  logic                          res_pop,
    output tmtw_pkg::result_t             res_head
);
    import tmtw_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_WAIT,
        ST_COPY,
        ST_BLANK
    } state_t;

    localparam logic [ROW_W-1:0] BOTTOM_ROW = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(CELL_COUNT - 1);
    localparam logic [CNT_W-1:0] END_CELL = CNT_W'(CELL_COUNT);
    localparam logic [CNT_W-1:0] ROW_CELLS = CNT_W'(SCREEN_COLUMNS);
    localparam logic [CNT_W-1:0] BOTTOM_CELL = CNT_W'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(32'(r) * SCREEN_COLUMNS + 32'(c));
    endfunction

    logic [CELL_W-1:0] screen_mem [CELL_COUNT];
    logic [CELL_W-1:0] mem_rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  idx_next;
    logic              copy_wr_valid_reg;
    logic              copy_wr_valid_next;
    logic [ADDR_W-1:0] copy_wr_addr_reg;
    logic [ADDR_W-1:0] copy_wr_addr_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [CHAR_W-1:0] color_reg;
    logic [CHAR_W-1:0] color_next;

    result_t           res_q_reg [2];
    logic              res_wr_ptr_reg;
    logic              res_wr_ptr_next;
    logic              res_rd_ptr_reg;
    logic              res_rd_ptr_next;
    logic [1:0]        res_count_reg;
    logic [1:0]        res_count_next;
    logic              res_push;
    result_t           res_item;
    logic              res_do_pop;

    assign clearing = (state_reg == ST_CLEAR);
    assign res_empty = (res_count_reg == 2'd0);
    assign res_head = res_q_reg[res_rd_ptr_reg];
    assign res_do_pop = res_pop & ~res_empty;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        copy_wr_valid_next = copy_wr_valid_reg;
        copy_wr_addr_next = copy_wr_addr_reg;
        row_next = row_reg;
        col_next = col_reg;
        color_next = color_we ? color_data : color_reg;
        mem_we = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = cell_addr(cmd.read_row, cmd.read_col);
        cmd_pop = 1'b0;
        res_push = 1'b0;
        res_item.cell_value = '0;
        res_item.cursor_row = row_reg;
        res_item.cursor_col = col_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_waddr = idx_reg[ADDR_W-1:0];
                mem_wdata = {RESET_COLOR, CH_SPACE};
                if (idx_reg == LAST_CELL)
                begin
                    idx_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid && res_count_reg != 2'd2)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        CMD_READ:
                        begin
                            state_next = ST_READ_WAIT;
                        end
                        CMD_READ_NONE, CMD_IGNORE:
                        begin
                            res_push = 1'b1;
                        end
                        CMD_NEWLINE:
                        begin
                            col_next = '0;
                            if (row_reg == BOTTOM_ROW)
                            begin
                                idx_next = ROW_CELLS;
                                state_next = ST_COPY;
                            end
                            else
                            begin
                                row_next = row_reg + 1'b1;
                                res_push = 1'b1;
                                res_item.cursor_row = row_reg + 1'b1;
                                res_item.cursor_col = '0;
                            end
                        end
                        CMD_BACKSPACE:
                        begin
                            if (col_reg == '0)
                            begin
                                if (row_reg != '0)
                                begin
                                    row_next = row_reg - 1'b1;
                                    col_next = LAST_COL;
                                end
                            end
                            else
                            begin
                                col_next = col_reg - 1'b1;
                            end
                            mem_we = 1'b1;
                            mem_waddr = cell_addr(row_next, col_next);
                            mem_wdata = {color_reg, CH_SPACE};
                            res_push = 1'b1;
                            res_item.cursor_row = row_next;
                            res_item.cursor_col = col_next;
                        end
                        CMD_PRINT:
                        begin
                            mem_we = 1'b1;
                            mem_waddr = cell_addr(row_reg, col_reg);
                            mem_wdata = {color_reg, cmd.char_code};
                            if (col_reg == LAST_COL)
                            begin
                                col_next = '0;
                                if (row_reg == BOTTOM_ROW)
                                begin
                                    idx_next = ROW_CELLS;
                                    state_next = ST_COPY;
                                end
                                else
                                begin
                                    row_next = row_reg + 1'b1;
                                    res_push = 1'b1;
                                    res_item.cursor_row = row_reg + 1'b1;
                                    res_item.cursor_col = '0;
                                end
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                                res_push = 1'b1;
                                res_item.cursor_col = col_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ_WAIT:
            begin
                res_push = 1'b1;
                res_item.cell_value = mem_rdata_reg;
                state_next = ST_IDLE;
            end
            ST_COPY:
            begin
                if (copy_wr_valid_reg)
                begin
                    mem_we = 1'b1;
                    mem_waddr = copy_wr_addr_reg;
                    mem_wdata = mem_rdata_reg;
                end
                if (idx_reg != END_CELL)
                begin
                    mem_raddr = idx_reg[ADDR_W-1:0];
                    copy_wr_valid_next = 1'b1;
                    copy_wr_addr_next = ADDR_W'(idx_reg - ROW_CELLS);
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    copy_wr_valid_next = 1'b0;
                    idx_next = BOTTOM_CELL;
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                mem_we = 1'b1;
                mem_waddr = idx_reg[ADDR_W-1:0];
                mem_wdata = {color_reg, CH_SPACE};
                if (idx_reg == LAST_CELL)
                begin
                    idx_next = '0;
                    res_push = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_wr_ptr_next = res_push ? ~res_wr_ptr_reg : res_wr_ptr_reg;
        res_rd_ptr_next = res_do_pop ? ~res_rd_ptr_reg : res_rd_ptr_reg;
        res_count_next = res_count_reg + {1'b0, res_push} - {1'b0, res_do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            idx_reg <= '0;
            copy_wr_valid_reg <= 1'b0;
            copy_wr_addr_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
            color_reg <= RESET_COLOR;
            res_wr_ptr_reg <= 1'b0;
            res_rd_ptr_reg <= 1'b0;
            res_count_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            copy_wr_valid_reg <= copy_wr_valid_next;
            copy_wr_addr_reg <= copy_wr_addr_next;
            row_reg <= row_next;
            col_reg <= col_next;
            color_reg <= color_next;
            res_wr_ptr_reg <= res_wr_ptr_next;
            res_rd_ptr_reg <= res_rd_ptr_next;
            res_count_reg <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_q_reg[res_wr_ptr_reg] <= res_item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= screen_mem[mem_raddr];
    end

endmodule

>>> design/text_mode_terminal_writer.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------
// input    | push / full          | opcode, char_code, read_row, read_col,
//          |                      | last_in_string
// result   | pop / empty          | cell_value, cursor_row, cursor_col
// config   | cfg_valid/cfg_ready  | cfg_data (text color)
//
// A printed character, carriage return, newline or backspace is handled by the
// engine, and a cell read goes through the registered read port of the screen memory.
// A scroll copies one cell per cycle through that single port and then blanks the
// bottom row. After reset full stays high while the screen is cleared. A two-entry
// command queue and a two-entry result queue let the input and result sides stall
// independently.
module text_mode_terminal_writer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          opcode,
    input  logic [tmtw_pkg::CHAR_W-1:0]   char_code,
    input  logic [tmtw_pkg::ROW_W-1:0]    read_row,
    input  logic [tmtw_pkg::COL_W-1:0]    read_col,
    input  logic                          last_in_string,
    output logic                          empty,
    input  logic                          pop,
    output logic [tmtw_pkg::CELL_W-1:0]   cell_value,
    output logic [tmtw_pkg::ROW_W-1:0]    cursor_row,
    output logic [tmtw_pkg::COL_W-1:0]    cursor_col,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tmtw_pkg::CHAR_W-1:0]   cfg_data
);
    import tmtw_pkg::*;

    cmd_t    front_cmd;
    cmd_t    queue_cmd;
    logic    q_push;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    logic    clearing;
    logic    string_end_unused;
    result_t res_head;

    assign cfg_ready = 1'b1;
    assign string_end_unused = last_in_string;

    tmtw_front u_front (
        .push      (push),
        .opcode    (opcode),
        .char_code (char_code),
        .read_row  (read_row),
        .read_col  (read_col),
        .q_full    (q_full),
        .clearing  (clearing),
        .full      (full),
        .q_push    (q_push),
        .cmd       (front_cmd)
    );

    tmtw_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .cmd_in  (front_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .cmd_out (queue_cmd)
    );

    tmtw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_valid),
        .cmd        (queue_cmd),
        .cmd_pop    (q_pop),
        .color_we   (cfg_valid & cfg_ready),
        .color_data (cfg_data),
        .clearing   (clearing),
        .res_empty  (empty),
        .res_pop    (pop),
        .res_head   (res_head)
    );

    assign cell_value = res_head.cell_value;
    assign cursor_row = res_head.cursor_row;
    assign cursor_col = res_head.cursor_col;

endmodule

>>> design/tmtw_checker.sv
module tmtw_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic [tmtw_pkg::CELL_W-1:0]   cell_value,
    input logic [tmtw_pkg::ROW_W-1:0]    cursor_row,
    input logic [tmtw_pkg::COL_W-1:0]    cursor_col
);
    import tmtw_pkg::*;

    // The cursor reported with every transaction stays on the screen.
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (32'(cursor_row) < SCREEN_ROWS) && (32'(cursor_col) < SCREEN_COLUMNS))
        else $error("reported cursor lies outside the screen");

    // The screen clear keeps the input side closed right after reset.
    a_full_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> full)
        else $error("input accepted while the screen is being cleared");

    // A pending result that is not taken stays in place.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(cell_value) && $stable(cursor_row)
                           && $stable(cursor_col))
        else $error("pending result changed before it was taken");

    // No result is pending right after reset, before any input has been accepted.
    a_no_result_from_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> empty)
        else $error("result shown right after reset");

endmodule

bind text_mode_terminal_writer tmtw_checker u_tmtw_checker (.*);

>>> tb/text_mode_terminal_writer_checker.sv
module text_mode_terminal_writer_checker
    import tmtw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  logic              opcode,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [ROW_W-1:0]  read_row,
    input  logic [COL_W-1:0]  read_col,
    input  logic              empty,
    input  logic              pop,
    input  logic [CELL_W-1:0] cell_value,
    input  logic [ROW_W-1:0]  cursor_row,
    input  logic [COL_W-1:0]  cursor_col,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CHAR_W-1:0] cfg_data,
    output int                pending_count,
    output int                failure_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CELL_W-1:0] screen_model [CELL_COUNT];
    int                cur_row;
    int                cur_col;
    logic [CHAR_W-1:0] text_attr;
    result_t           expected_results [$];
    int                mismatch_total;

    function automatic void advance_line();
        cur_col = 0;
        cur_row++;
        if (cur_row >= SCREEN_ROWS)
        begin
            for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLUMNS; i++)
                screen_model[i] = screen_model[i + SCREEN_COLUMNS];
            for (int i = 0; i < SCREEN_COLUMNS; i++)
                screen_model[(SCREEN_ROWS - 1) * SCREEN_COLUMNS + i] = {text_attr, CH_SPACE};
            cur_row = SCREEN_ROWS - 1;
        end
    endfunction

    function automatic result_t predict_terminal(input logic op, input logic [CHAR_W-1:0] ch,
                                                 input logic [ROW_W-1:0] rr,
                                                 input logic [COL_W-1:0] rc);
        result_t res;
        res.cell_value = '0;
        if (op == OP_READ)
        begin
            if (rr < SCREEN_ROWS && rc < SCREEN_COLUMNS)
                res.cell_value = screen_model[int'(rr) * SCREEN_COLUMNS + int'(rc)];
        end
        else if (ch == CH_LF)
        begin
            advance_line();
        end
        else if (ch == CH_BS)
        begin
            if (cur_col == 0)
            begin
                if (cur_row != 0)
                begin
                    cur_row--;
                    cur_col = SCREEN_COLUMNS - 1;
                end
            end
            else
            begin
                cur_col--;
            end
            screen_model[cur_row * SCREEN_COLUMNS + cur_col] = {text_attr, CH_SPACE};
        end
        else if (ch != CH_CR)
        begin
            screen_model[cur_row * SCREEN_COLUMNS + cur_col] = {text_attr, ch};
            cur_col++;
            if (cur_col >= SCREEN_COLUMNS)
                advance_line();
        end
        res.cursor_row = cur_row[ROW_W-1:0];
        res.cursor_col = cur_col[COL_W-1:0];
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [CELL_W-1:0] want,
                                        input logic [CELL_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_total++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CELL_COUNT; i++)
                screen_model[i] = {RESET_COLOR, CH_SPACE};
            cur_row = 0;
            cur_col = 0;
            text_attr = RESET_COLOR;
            expected_results.delete();
            mismatch_total = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                text_attr = cfg_data;
            // The result transaction is checked before the new input transaction is predicted,
            // so a push on the same edge can never satisfy a pop.
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0h %0d %0d",
                             $time, cell_value, cursor_row, cursor_col);
                    mismatch_total++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("cell_value", want.cell_value, cell_value);
                    check_field("cursor_row", CELL_W'(want.cursor_row), CELL_W'(cursor_row));
                    check_field("cursor_col", CELL_W'(want.cursor_col), CELL_W'(cursor_col));
                end
            end
            if (push && !full)
                expected_results.push_back(predict_terminal(opcode, char_code, read_row,
                                                            read_col));
        end
        pending_count <= expected_results.size();
        failure_count <= mismatch_total;
    end

endmodule

>>> tb/text_mode_terminal_writer_tb.sv
module text_mode_terminal_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tmtw_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic              opcode;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
    logic              last_in_string;
    logic              empty;
    logic              pop;
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CHAR_W-1:0] cfg_data;

    int                pending_count;
    int                failure_count;
    int                items_sent;
    int                hold_left;
    bit                hold_start;
    bit                idle_on;

    text_mode_terminal_writer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .opcode         (opcode),
        .char_code      (char_code),
        .read_row       (read_row),
        .read_col       (read_col),
        .last_in_string (last_in_string),
        .empty          (empty),
        .pop            (pop),
        .cell_value     (cell_value),
        .cursor_row     (cursor_row),
        .cursor_col     (cursor_col),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    text_mode_terminal_writer_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .char_code     (char_code),
        .read_row      (read_row),
        .read_col      (read_col),
        .empty         (empty),
        .pop           (pop),
        .cell_value    (cell_value),
        .cursor_row    (cursor_row),
        .cursor_col    (cursor_col),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .pending_count (pending_count),
        .failure_count (failure_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        pop <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_start)
            begin
                hold_start = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if (idle_on && $urandom_range(0, 99) < 29)
            begin
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch,
                             input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                             input logic last);
        while (idle_on && $urandom_range(0, 99) < 29)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        opcode <= op;
        char_code <= ch;
        read_row <= rr;
        read_col <= rc;
        last_in_string <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
        send_item(OP_WRITE, ch, ROW_W'($urandom), COL_W'($urandom), last);
    endtask

    task automatic send_read(input int rr, input int rc);
        send_item(OP_READ, CHAR_W'($urandom), ROW_W'(rr), COL_W'(rc), 1'($urandom));
    endtask

    function automatic logic [CHAR_W-1:0] random_char();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return CH_BS;
        if (pick == 1)
            return CH_CR;
        if (pick == 2)
            return CH_LF;
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic send_string(input int len);
        for (int i = 0; i < len; i++)
            send_char(random_char(), i == len - 1);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_color(input logic [CHAR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(input int count);
        int target;
        int sel;
        target = items_sent + count;
        while (items_sent < target)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 60)
            begin
                send_string(($urandom_range(0, 9) == 0) ? $urandom_range(60, 100)
                                                        : $urandom_range(1, 12));
                if ($urandom_range(0, 1) == 1)
                    send_char(CH_LF, 1'b0);
            end
            else if (sel < 85)
            begin
                send_read($urandom_range(0, SCREEN_ROWS - 1),
                          $urandom_range(0, SCREEN_COLUMNS - 1));
            end
            else if (sel < 92)
            begin
                send_read($urandom_range(0, 31), $urandom_range(0, 127));
            end
            else
            begin
                send_item(1'($urandom), CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom),
                          1'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        push <= 1'b0;
        opcode <= OP_WRITE;
        char_code <= '0;
        read_row <= '0;
        read_col <= '0;
        last_in_string <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        items_sent = 0;
        hold_start = 1'b0;
        idle_on = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_read(0, 0);
        send_read(SCREEN_ROWS - 1, SCREEN_COLUMNS - 1);
        send_read(SCREEN_ROWS, 0);
        send_read(0, SCREEN_COLUMNS);
        send_read(31, 127);
        send_char(CH_BS, 1'b0);
        send_char(CH_CR, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h41, 1'b1);
        send_char(CH_BS, 1'b0);
        send_char(CH_LF, 1'b0);
        send_char(CH_BS, 1'b0);
        send_char(8'h57, 1'b1);
        send_read(0, SCREEN_COLUMNS - 1);
        send_read(0, 1);
        send_char(8'h7F, 1'b1);
        send_read(1, 0);

        drain_results();
        write_color(8'hFF);
        send_char(8'h5A, 1'b0);
        send_char(CH_BS, 1'b0);
        send_read(1, 1);
        send_char(8'h80, 1'b1);

        drain_results();
        write_color(8'h00);
        random_traffic(100);

        drain_results();
        write_color(CHAR_W'($urandom));
        idle_on = 1'b0;
        random_traffic(100);

        drain_results();
        write_color(CHAR_W'($urandom));
        hold_start = 1'b1;
        for (int i = 0; i < 30; i++)
            send_char(CHAR_W'($urandom_range(33, 126)), i == 29);
        idle_on = 1'b1;
        random_traffic(70);

        drain_results();
        write_color(CHAR_W'($urandom));
        random_traffic(100);

        drain_results();
        write_color(RESET_COLOR);
        random_traffic(100);

        drain_results();
        repeat (50) @(posedge clk);
        if (failure_count == 0 && pending_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
